// ----- sv/svm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types and constants of the sample voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int SampleWordsDef = 65536;
  localparam int ClipEntriesDef = 16;
  localparam int VoiceSlotsDef  = 8;

  localparam int GainW     = 20;
  localparam int GainShift = 16;
  localparam logic [GainW-1:0] GainUnity = GainW'(1 << GainShift);
  localparam logic signed [21:0] MixMin = -22'sd32767;
  localparam logic signed [21:0] MixMax = 22'sd32766;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_DEFINE = 2'd1,
    OP_PLAY   = 2'd2,
    OP_MIX    = 2'd3
  } op_t;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NO_CLIP = 2'd1;
  localparam logic [1:0] STS_NO_VOICE = 2'd2;
  localparam logic [1:0] STS_RANGE   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PLAY_SCAN,
    S_MIX_VISIT,
    S_MIX_READ,
    S_MIX_ACC,
    S_DONE
  } state_t;

  // One queued item with its classification flags.
  typedef struct packed {
    op_t                op;
    logic [15:0]        address;
    logic [15:0]        sample_word;
    logic [3:0]         clip_id;
    logic [15:0]        clip_length;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               addr_ok;
    logic               def_ok;
    logic               cid_ok;
  } item_t;

endpackage

// ----- sv/sample_voice_mixer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_mixer
// Multi-voice sample playback mixer with clip table and APB gain control.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | start / busy         | in_operation .. in_right
//  result   | out_valid (1 cycle)  | out_left, out_right, out_status,
//           |                      | out_voices_active
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata
//
// A write, define or play-miss item runs its execute step only; a play also
// scans the voice slots for the lowest free one. A mix visits each slot in
// turn and, for a sounding slot, reads the sample, multiplies and clamps,
// in the single sequential voice loop. A two-item queue lets the next
// item in while the back end works. Synchronous reset clears the clip table
// and voices at once; the sample memory is not cleared. Results cannot stall.
// ----------------------------------------------------------------------------
module sample_voice_mixer #(
  parameter int SampleWords = svm_pkg::SampleWordsDef,
  parameter int ClipEntries = svm_pkg::ClipEntriesDef,
  parameter int VoiceSlots  = svm_pkg::VoiceSlotsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [15:0]         in_address,
  input  logic [15:0]         in_sample_word,
  input  logic [3:0]          in_clip_id,
  input  logic [15:0]         in_clip_length,
  input  logic signed [15:0]  in_left,
  input  logic signed [15:0]  in_right,
  output logic                out_valid,
  output logic signed [15:0]  out_left,
  output logic signed [15:0]  out_right,
  output logic [1:0]          out_status,
  output logic [3:0]          out_voices_active,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import svm_pkg::*;

  localparam int SaW = $clog2(SampleWords);

  logic [GainW-1:0] gain_r;
  logic             mute_r;
  logic [GainW-1:0] gain_eff;
  logic             cfg_wr;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;
  logic             ram_we, ram_re;
  logic [SaW-1:0]   ram_waddr, ram_raddr;
  logic [15:0]      ram_wdata, ram_rdata;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = paddr[2] ? {31'b0, mute_r} : {12'b0, gain_r};
  assign gain_eff = mute_r ? '0 : gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GainUnity;
      mute_r <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        mute_r <= pwdata[0];
      end else begin
        gain_r <= pwdata[GainW-1:0];
      end
    end
  end

  svm_front #(
    .SampleWords (SampleWords),
    .ClipEntries (ClipEntries)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_address     (in_address),
    .in_sample_word (in_sample_word),
    .in_clip_id     (in_clip_id),
    .in_clip_length (in_clip_length),
    .in_left        (in_left),
    .in_right       (in_right),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  svm_back #(
    .SampleWords (SampleWords),
    .ClipEntries (ClipEntries),
    .VoiceSlots  (VoiceSlots)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .gain              (gain_eff),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_left          (out_left),
    .out_right         (out_right),
    .out_status        (out_status),
    .out_voices_active (out_voices_active)
  );

  svm_ram #(
    .Width (16),
    .Depth (SampleWords)
  ) u_sample_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- sv/svm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svm_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/svm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_front
// Accepts items, checks their ranges and queues them for the back end.
// ----------------------------------------------------------------------------
module svm_front #(
  parameter int SampleWords = svm_pkg::SampleWordsDef,
  parameter int ClipEntries = svm_pkg::ClipEntriesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [15:0]         in_address,
  input  logic [15:0]         in_sample_word,
  input  logic [3:0]          in_clip_id,
  input  logic [15:0]         in_clip_length,
  input  logic signed [15:0]  in_left,
  input  logic signed [15:0]  in_right,
  output logic                q_valid,
  output svm_pkg::item_t      q_item,
  input  logic                q_pop
);
  import svm_pkg::*;

  localparam logic [31:0] Sw32 = 32'(SampleWords);
  localparam logic [31:0] Ce32 = 32'(ClipEntries);

  item_t       q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       new_item;
  logic        push;
  logic [31:0] addr32;
  logic [31:0] end32;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rd_ptr_r];

  always_comb begin
    addr32               = {16'b0, in_address};
    end32                = addr32 + {16'b0, in_clip_length};
    new_item.op          = op_t'(in_operation);
    new_item.address     = in_address;
    new_item.sample_word = in_sample_word;
    new_item.clip_id     = in_clip_id;
    new_item.clip_length = in_clip_length;
    new_item.left        = in_left;
    new_item.right       = in_right;
    new_item.addr_ok     = addr32 < Sw32;
    new_item.def_ok      = (addr32 < Sw32) && (end32 <= Sw32);
    new_item.cid_ok      = {28'b0, in_clip_id} < Ce32;
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ----- sv/svm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_back
// Executes queued items: sample writes, clip table, voice allocation, mixing.
// ----------------------------------------------------------------------------
module svm_back #(
  parameter int SampleWords = svm_pkg::SampleWordsDef,
  parameter int ClipEntries = svm_pkg::ClipEntriesDef,
  parameter int VoiceSlots  = svm_pkg::VoiceSlotsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  svm_pkg::item_t                   q_item,
  output logic                             q_pop,
  input  logic [svm_pkg::GainW-1:0]        gain,
  output logic                             ram_we,
  output logic [$clog2(SampleWords)-1:0]   ram_waddr,
  output logic [15:0]                      ram_wdata,
  output logic                             ram_re,
  output logic [$clog2(SampleWords)-1:0]   ram_raddr,
  input  logic [15:0]                      ram_rdata,
  output logic                             out_valid,
  output logic signed [15:0]               out_left,
  output logic signed [15:0]               out_right,
  output logic [1:0]                       out_status,
  output logic [3:0]                       out_voices_active
);
  import svm_pkg::*;

  localparam int SaW  = $clog2(SampleWords);
  localparam int CiW  = (ClipEntries > 1) ? $clog2(ClipEntries) : 1;
  localparam int SiW  = (VoiceSlots > 1) ? $clog2(VoiceSlots) : 1;
  localparam int CntW = $clog2(VoiceSlots + 1);
  localparam logic [31:0] Sw32 = 32'(SampleWords);
  localparam logic [31:0] Ce32 = 32'(ClipEntries);
  localparam logic [SiW-1:0] LastSlot = SiW'(VoiceSlots - 1);

  state_t state_r, state_nxt;
  item_t  item_r, item_nxt;
  logic signed [15:0] left_r, left_nxt, right_r, right_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [SiW-1:0]     slot_r, slot_nxt;
  logic [15:0]        size_r, size_nxt;
  logic signed [36:0] prod_r, prod_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;

  logic [15:0] cstart_r [ClipEntries];
  logic [15:0] csize_r  [ClipEntries];
  logic        cvalid_r [ClipEntries];
  logic [15:0] cstart_nxt [ClipEntries];
  logic [15:0] csize_nxt  [ClipEntries];
  logic        cvalid_nxt [ClipEntries];
  logic        vbusy_r [VoiceSlots];
  logic [3:0]  vclip_r [VoiceSlots];
  logic [15:0] vpos_r  [VoiceSlots];
  logic        vbusy_nxt [VoiceSlots];
  logic [3:0]  vclip_nxt [VoiceSlots];
  logic [15:0] vpos_nxt  [VoiceSlots];

  logic [3:0]         clip_sel;
  logic [CiW-1:0]     clip_idx;
  logic [31:0]        clip_sel32;
  logic               vclip_ok;
  logic [31:0]        sum32;
  logic [31:0]        addr32;
  logic [16:0]        pos_inc;
  logic signed [20:0] contrib;
  logic signed [21:0] sum_l, sum_r;
  logic [31:0]        cnt32;

  assign clip_sel   = (state_r == S_EXEC) ? item_r.clip_id : vclip_r[slot_r];
  assign clip_sel32 = {28'b0, clip_sel};
  assign clip_idx   = clip_sel32[CiW-1:0];
  assign vclip_ok   = clip_sel32 < Ce32;

  always_comb begin
    sum32 = {16'b0, cstart_r[clip_idx]} + {16'b0, vpos_r[slot_r]};
    if (sum32 >= Sw32) begin
      sum32 = sum32 - Sw32;
    end
    addr32 = {16'b0, item_r.address};
  end

  assign pos_inc  = {1'b0, vpos_r[slot_r]} + 17'd1;
  assign contrib  = prod_r[36:16];
  assign sum_l    = 22'(left_r) + 22'(contrib);
  assign sum_r    = 22'(right_r) + 22'(contrib);
  assign cnt32    = 32'(cnt_r);

  assign ram_waddr = addr32[SaW-1:0];
  assign ram_wdata = item_r.sample_word;
  assign ram_raddr = sum32[SaW-1:0];

  assign out_valid         = (state_r == S_DONE);
  assign out_left          = left_r;
  assign out_right         = right_r;
  assign out_status        = status_r;
  assign out_voices_active = cnt32[3:0];

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    size_nxt   = size_r;
    prod_nxt   = prod_r;
    cnt_nxt    = cnt_r;
    cstart_nxt = cstart_r;
    csize_nxt  = csize_r;
    cvalid_nxt = cvalid_r;
    vbusy_nxt  = vbusy_r;
    vclip_nxt  = vclip_r;
    vpos_nxt   = vpos_r;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          item_nxt   = q_item;
          status_nxt = STS_OK;
          left_nxt   = (q_item.op == OP_MIX) ? q_item.left : 16'sd0;
          right_nxt  = (q_item.op == OP_MIX) ? q_item.right : 16'sd0;
          slot_nxt   = '0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (item_r.op)
          OP_WRITE: begin
            if (item_r.addr_ok) begin
              ram_we = 1'b1;
            end else begin
              status_nxt = STS_RANGE;
            end
          end
          OP_DEFINE: begin
            if (!item_r.cid_ok) begin
              status_nxt = STS_NO_CLIP;
            end else if (!item_r.def_ok) begin
              status_nxt = STS_RANGE;
            end else begin
              cstart_nxt[clip_idx] = item_r.address;
              csize_nxt[clip_idx]  = item_r.clip_length;
              cvalid_nxt[clip_idx] = 1'b1;
            end
          end
          OP_PLAY: begin
            if (!item_r.cid_ok || !cvalid_r[clip_idx]) begin
              status_nxt = STS_NO_CLIP;
            end else if (csize_r[clip_idx] != 16'd0) begin
              state_nxt = S_PLAY_SCAN;
            end
          end
          OP_MIX: begin
            state_nxt = S_MIX_VISIT;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_PLAY_SCAN: begin
        // take the lowest free slot
        if (!vbusy_r[slot_r]) begin
          vbusy_nxt[slot_r] = 1'b1;
          vclip_nxt[slot_r] = item_r.clip_id;
          vpos_nxt[slot_r]  = 16'd0;
          cnt_nxt           = cnt_r + CntW'(1);
          state_nxt         = S_DONE;
        end else if (slot_r == LastSlot) begin
          status_nxt = STS_NO_VOICE;
          state_nxt  = S_DONE;
        end else begin
          slot_nxt = slot_r + SiW'(1);
        end
      end
      S_MIX_VISIT: begin
        if (vbusy_r[slot_r] && vclip_ok && (vpos_r[slot_r] < csize_r[clip_idx])) begin
          ram_re    = 1'b1;
          size_nxt  = csize_r[clip_idx];
          state_nxt = S_MIX_READ;
        end else begin
          if (vbusy_r[slot_r]) begin
            // clip shrank under this voice: drop it silently
            vbusy_nxt[slot_r] = 1'b0;
            cnt_nxt           = cnt_r - CntW'(1);
          end
          if (slot_r == LastSlot) begin
            state_nxt = S_DONE;
          end else begin
            slot_nxt = slot_r + SiW'(1);
          end
        end
      end
      S_MIX_READ: begin
        prod_nxt  = 37'($signed(ram_rdata)) * 37'($signed({1'b0, gain}));
        state_nxt = S_MIX_ACC;
      end
      S_MIX_ACC: begin
        if (sum_l < MixMin) begin
          left_nxt = 16'(MixMin);
        end else if (sum_l > MixMax) begin
          left_nxt = 16'(MixMax);
        end else begin
          left_nxt = sum_l[15:0];
        end
        if (sum_r < MixMin) begin
          right_nxt = 16'(MixMin);
        end else if (sum_r > MixMax) begin
          right_nxt = 16'(MixMax);
        end else begin
          right_nxt = sum_r[15:0];
        end
        vpos_nxt[slot_r] = pos_inc[15:0];
        if (pos_inc >= {1'b0, size_r}) begin
          vbusy_nxt[slot_r] = 1'b0;
          cnt_nxt           = cnt_r - CntW'(1);
        end
        if (slot_r == LastSlot) begin
          state_nxt = S_DONE;
        end else begin
          slot_nxt  = slot_r + SiW'(1);
          state_nxt = S_MIX_VISIT;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      cstart_r <= '{default: '0};
      csize_r  <= '{default: '0};
      cvalid_r <= '{default: 1'b0};
      vbusy_r  <= '{default: 1'b0};
      vclip_r  <= '{default: '0};
      vpos_r   <= '{default: '0};
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      cstart_r <= cstart_nxt;
      csize_r  <= csize_nxt;
      cvalid_r <= cvalid_nxt;
      vbusy_r  <= vbusy_nxt;
      vclip_r  <= vclip_nxt;
      vpos_r   <= vpos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    size_r   <= size_nxt;
    prod_r   <= prod_nxt;
  end

endmodule

// ----- tb/svm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_checker
// Scoreboard for the sample voice mixer. It snoops accepted items and APB
// writes, keeps its own copy of the sample memory, clip table, voices and
// gain, and compares every result strobe with the oldest predicted frame.
// ----------------------------------------------------------------------------
module svm_checker #(
  parameter logic [2:0] GainAddr = 3'd0,
  parameter logic [2:0] MuteAddr = 3'd4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_address,
  input  logic [15:0]        in_sample_word,
  input  logic [3:0]         in_clip_id,
  input  logic [15:0]        in_clip_length,
  input  logic signed [15:0] in_left,
  input  logic signed [15:0] in_right,
  input  logic               out_valid,
  input  logic signed [15:0] out_left,
  input  logic signed [15:0] out_right,
  input  logic [1:0]         out_status,
  input  logic [3:0]         out_voices_active,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 frames_pending
);
  import svm_pkg::*;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [1:0]         status;
    logic [3:0]         active;
  } frame_t;

  frame_t              frame_q[$];
  logic signed [15:0]  sample_mem [SampleWordsDef];
  logic [15:0]         clip_base  [ClipEntriesDef];
  logic [15:0]         clip_len   [ClipEntriesDef];
  logic                clip_def   [ClipEntriesDef];
  logic                voice_on   [VoiceSlotsDef];
  logic [3:0]          voice_cid  [VoiceSlotsDef];
  logic [15:0]         voice_pos  [VoiceSlotsDef];
  logic [GainW-1:0]    gain_reg;
  logic                mute_reg;

  assign frames_pending = frame_q.size();

  function automatic int clamp_mix(int v);
    if (v < int'(MixMin)) return int'(MixMin);
    if (v > int'(MixMax)) return int'(MixMax);
    return v;
  endfunction

  task automatic predict_frame(output frame_t f);
    int     lsum, rsum, slot, n;
    longint g, contrib;
    logic [15:0] a;
    lsum = in_left;
    rsum = in_right;
    f.status = STS_OK;
    f.left = '0;
    f.right = '0;
    case (op_t'(in_operation))
      OP_WRITE: sample_mem[in_address] = in_sample_word;
      OP_DEFINE: begin
        if (32'(in_address) + 32'(in_clip_length) > SampleWordsDef) begin
          f.status = STS_RANGE;
        end else begin
          clip_base[in_clip_id] = in_address;
          clip_len[in_clip_id]  = in_clip_length;
          clip_def[in_clip_id]  = 1'b1;
        end
      end
      OP_PLAY: begin
        if (!clip_def[in_clip_id]) begin
          f.status = STS_NO_CLIP;
        end else if (clip_len[in_clip_id] != 0) begin
          slot = -1;
          for (int i = 0; i < VoiceSlotsDef; i++)
            if (!voice_on[i] && slot < 0) slot = i;
          if (slot < 0) begin
            f.status = STS_NO_VOICE;
          end else begin
            voice_on[slot]  = 1'b1;
            voice_cid[slot] = in_clip_id;
            voice_pos[slot] = '0;
          end
        end
      end
      default: begin
        g = mute_reg ? 0 : longint'(gain_reg);
        for (int i = 0; i < VoiceSlotsDef; i++) begin
          if (voice_on[i]) begin
            if (voice_pos[i] >= clip_len[voice_cid[i]]) begin
              // clip shrank under the voice: drop it silently
              voice_on[i] = 1'b0;
            end else begin
              a = clip_base[voice_cid[i]] + voice_pos[i];
              contrib = (longint'(sample_mem[a]) * g) >>> GainShift;
              lsum = clamp_mix(lsum + int'(contrib));
              rsum = clamp_mix(rsum + int'(contrib));
              voice_pos[i] = voice_pos[i] + 16'd1;
              if (voice_pos[i] >= clip_len[voice_cid[i]]) voice_on[i] = 1'b0;
            end
          end
        end
        f.left  = lsum[15:0];
        f.right = rsum[15:0];
      end
    endcase
    n = 0;
    for (int i = 0; i < VoiceSlotsDef; i++) if (voice_on[i]) n++;
    f.active = 4'(n);
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    frame_t f, e;
    if (!rst_n) begin
      frame_q.delete();
      for (int i = 0; i < ClipEntriesDef; i++) begin
        clip_base[i] = '0;
        clip_len[i]  = '0;
        clip_def[i]  = 1'b0;
      end
      for (int i = 0; i < VoiceSlotsDef; i++) begin
        voice_on[i]  = 1'b0;
        voice_cid[i] = '0;
        voice_pos[i] = '0;
      end
      gain_reg = GainUnity;
      mute_reg = 1'b0;
    end else begin
      if (out_valid) begin
        if (frame_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, got left %0d right %0d status %0d",
                   $time, out_left, out_right, out_status);
        end else begin
          e = frame_q.pop_front();
          check_field("left", e.left, out_left);
          check_field("right", e.right, out_right);
          check_field("status", e.status, out_status);
          check_field("voices_active", e.active, out_voices_active);
        end
      end
      if (start && !busy) begin
        predict_frame(f);
        frame_q.push_back(f);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == GainAddr) gain_reg = pwdata[GainW-1:0];
        else if (paddr == MuteAddr) mute_reg = pwdata[0];
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sample voice mixer: preloads samples, runs a
// directed sequence of clip and voice corner cases, then random phases under
// several gain and mute settings with varying sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
  import svm_pkg::*;

  localparam logic [2:0] GainAddr = 3'd0;
  localparam logic [2:0] MuteAddr = 3'd4;
  localparam int PoolTop  = 64;
  localparam int HighBase = 65520;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_operation = '0;
  logic [15:0]        in_address = '0;
  logic [15:0]        in_sample_word = '0;
  logic [3:0]         in_clip_id = '0;
  logic [15:0]        in_clip_length = '0;
  logic signed [15:0] in_left = '0;
  logic signed [15:0] in_right = '0;
  logic               out_valid;
  logic signed [15:0] out_left, out_right;
  logic [1:0]         out_status;
  logic [3:0]         out_voices_active;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors, frames_pending;
  int                 idle_pct = 0;
  int                 item_count = 0, mix_count = 0, play_count = 0;

  sample_voice_mixer dut (.*);

  svm_checker #(.GainAddr(GainAddr), .MuteAddr(MuteAddr)) checker_i (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic issue_item(op_t op, logic [15:0] addr, logic [15:0] word,
                            logic [3:0] cid, logic [15:0] len,
                            logic [15:0] l, logic [15:0] r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_address     <= addr;
    in_sample_word <= word;
    in_clip_id     <= cid;
    in_clip_length <= len;
    in_left        <= l;
    in_right       <= r;
    do @(posedge clk); while (busy);
    item_count++;
    if (op == OP_MIX) mix_count++;
    if (op == OP_PLAY) play_count++;
  endtask

  task automatic drain_frames();
    start <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int pick, s, len;
    pick = $urandom_range(99);
    if (pick < 35) begin
      issue_item(OP_MIX, 16'($urandom), 16'($urandom), 4'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
    end else if (pick < 60) begin
      issue_item(OP_PLAY, 16'($urandom), 16'($urandom), 4'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
    end else if (pick < 75) begin
      // keep good clips inside the preloaded windows
      if ($urandom_range(3) == 0) begin
        s = HighBase + $urandom_range(15);
        len = $urandom_range(65536 - s);
      end else begin
        s = $urandom_range(PoolTop - 1);
        len = $urandom_range(PoolTop - s < 24 ? PoolTop - s : 24);
      end
      issue_item(OP_DEFINE, 16'(s), 16'($urandom), 4'($urandom), 16'(len),
                 16'($urandom), 16'($urandom));
    end else if (pick < 80) begin
      s = $urandom_range(2, 65535);
      issue_item(OP_DEFINE, 16'(s), 16'($urandom), 4'($urandom),
                 16'($urandom_range(65537 - s, 65535)), 16'($urandom), 16'($urandom));
    end else if (pick < 90) begin
      issue_item(OP_WRITE, 16'($urandom_range(PoolTop - 1)), 16'($urandom),
                 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      issue_item(OP_WRITE, 16'($urandom), 16'($urandom), 4'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [31:0] gain_set [6];
    logic        mute_set [6];
    gain_set = '{32'h10000, 32'h10000, 32'd655360, 32'hFFFFF, 32'd0, 32'h0};
    mute_set = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    gain_set[5] = $urandom_range(32'hFFFFF);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 36;

    // fill the sample windows that clips may cover
    for (int i = 0; i < PoolTop; i++)
      issue_item(OP_WRITE, 16'(i), i == 0 ? 16'h7FFF : i == 1 ? 16'h8000 : 16'($urandom),
                 '0, '0, '0, '0);
    for (int i = HighBase; i < 65536; i++)
      issue_item(OP_WRITE, 16'(i), 16'($urandom), 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    issue_item(OP_PLAY, '0, '0, 4'd3, '0, '0, '0);              // undefined clip
    issue_item(OP_MIX, '0, '0, '0, '0, 16'h8000, 16'h7FFF);     // passthrough
    issue_item(OP_DEFINE, 16'd0, '0, 4'd0, 16'd64, '0, '0);
    issue_item(OP_DEFINE, 16'd0, '0, 4'd1, 16'd0, '0, '0);
    issue_item(OP_PLAY, '0, '0, 4'd1, '0, '0, '0);              // zero-length clip
    issue_item(OP_DEFINE, 16'(HighBase), '0, 4'd2, 16'd16, '0, '0);
    issue_item(OP_DEFINE, 16'hFFFF, '0, 4'd3, 16'd2, '0, '0);   // past end of memory
    issue_item(OP_DEFINE, 16'd0, '0, 4'd4, 16'd2, '0, '0);
    issue_item(OP_PLAY, '0, '0, 4'd4, '0, '0, '0);
    issue_item(OP_PLAY, '0, '0, 4'd2, '0, '0, '0);
    repeat (6) issue_item(OP_PLAY, '0, '0, 4'd0, '0, '0, '0);
    issue_item(OP_PLAY, '0, '0, 4'd0, '0, '0, '0);              // all slots taken
    issue_item(OP_MIX, '0, '0, '0, '0, 16'h7FFF, 16'h8000);
    issue_item(OP_MIX, '0, '0, '0, '0, 16'h7FFF, 16'h8000);
    issue_item(OP_MIX, '0, '0, '0, '0, 16'h0000, 16'hFFFF);
    issue_item(OP_DEFINE, 16'd10, '0, 4'd0, 16'd1, '0, '0);     // shrink under voices
    issue_item(OP_MIX, '0, '0, '0, '0, 16'h1234, 16'hEDCB);

    for (int ph = 0; ph < 6; ph++) begin
      drain_frames();
      write_reg(GainAddr, gain_set[ph]);
      write_reg(MuteAddr, 32'(mute_set[ph]));
      idle_pct = ph < 2 ? 36 : ph < 4 ? 77 : 0;
      repeat (175) random_item();
    end
    drain_frames();

    $display("Covered %0d items (%0d mixes, %0d plays) across six gain/mute settings",
             item_count, mix_count, play_count);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
